// ===== rtl/lz4_block_decompressor_assert.svh =====
// Assertion macros for the LZ4 block decompressor.
`ifndef LZ4_BLOCK_DECOMPRESSOR_ASSERT_SVH
`define LZ4_BLOCK_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define LZ4BD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lz4bd assertion failed");

// Next-cycle implication checked at every clock edge outside reset.
`define LZ4BD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lz4bd assertion failed");

`endif

// ===== rtl/lz4bd_pkg.sv =====
// Types and constants shared by the LZ4 block decompressor modules.
package lz4bd_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_ZERO_OFF  = 3'd2;
    localparam logic [2:0] ST_FAR_OFF   = 3'd3;
    localparam logic [2:0] ST_CAPACITY  = 3'd4;

    localparam logic CFG_OUT_CAPACITY = 1'b0;
    localparam logic CFG_MIN_MATCH    = 1'b1;

    localparam logic [24:0] RUN_MAX = 25'h1FF_FFFF;
    localparam logic [3:0]  NIB_EXT = 4'hF;
    localparam logic [7:0]  BYTE_EXT = 8'hFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_data;
        logic [3:0]  out_count;
        logic        out_last;
        logic [2:0]  out_status;
    } t_out_item;

    typedef enum logic [5:0] {
        PH_TOKEN  = 6'b000001,
        PH_LITEXT = 6'b000010,
        PH_LIT    = 6'b000100,
        PH_OFF0   = 6'b001000,
        PH_OFF1   = 6'b010000,
        PH_MEXT   = 6'b100000
    } t_phase;

    typedef enum logic [3:0] {
        SQ_IDLE = 4'b0001,
        SQ_RD   = 4'b0010,
        SQ_WR   = 4'b0100,
        SQ_EMIT = 4'b1000
    } t_seq;

    // Per-request parser state
    typedef struct packed {
        t_phase      phase;
        logic [3:0]  nibble;
        logic [24:0] run;
        logic [15:0] offset;
        logic [24:0] produced;
        logic        err;
        logic [2:0]  code;
    } t_pstate;

    // Parser decision for one request
    typedef struct packed {
        t_pstate    nxt;
        logic       emit;
        t_out_item  res;
        logic       lit_wr;
        logic       copy;
        logic [8:0] copy_len;
    } t_dec;

endpackage

// ===== rtl/lz4bd_ring.sv =====
// History ring memory: one write port, one registered read port.
module lz4bd_ring #(
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/lz4bd_parse.sv =====
// Token, length, literal and offset parser for one compressed byte.
module lz4bd_parse import lz4bd_pkg::*; (
    input  t_in_item    i_item,
    input  t_pstate     i_st,
    input  logic [23:0] i_cap,
    input  logic [3:0]  i_min,
    output t_dec        o_dec
);
    logic [7:0]  b;
    logic        last;
    logic [3:0]  lit;
    logic        fail;
    logic [2:0]  fcode;
    logic        match;
    logic [8:0]  mlen;
    logic [25:0] rsum;
    logic [24:0] rsat;
    logic [15:0] off;

    always_comb begin
        b     = i_item.in_byte;
        last  = i_item.in_last;
        lit   = b[7:4];
        fail  = 1'b0;
        fcode = ST_OK;
        match = 1'b0;
        mlen  = '0;
        rsum  = {1'b0, i_st.run} + {18'd0, b};
        rsat  = rsum[25] ? RUN_MAX : rsum[24:0];
        off   = {b, i_st.offset[7:0]};
        o_dec = '0;
        o_dec.nxt = i_st;

        case (i_st.phase)
            PH_TOKEN: begin
                o_dec.nxt.nibble = b[3:0];
                if (lit == NIB_EXT) begin
                    o_dec.nxt.run   = 25'd15;
                    o_dec.nxt.phase = PH_LITEXT;
                    if (last) begin
                        fail = 1'b1; fcode = ST_TRUNCATED;
                    end
                end else if (lit != 4'd0) begin
                    if ({1'b0, i_st.produced} + {22'd0, lit} > {2'b0, i_cap}) begin
                        fail = 1'b1; fcode = ST_CAPACITY;
                    end else begin
                        o_dec.nxt.run   = {21'd0, lit};
                        o_dec.nxt.phase = PH_LIT;
                        if (last) begin
                            fail = 1'b1; fcode = ST_TRUNCATED;
                        end
                    end
                end else begin
                    o_dec.nxt.phase = PH_OFF0;
                end
            end
            PH_LITEXT: begin
                o_dec.nxt.run = rsat;
                if (b == BYTE_EXT) begin
                    if (last) begin
                        fail = 1'b1; fcode = ST_TRUNCATED;
                    end
                end else if ({1'b0, i_st.produced} + {1'b0, rsat} > {2'b0, i_cap}) begin
                    fail = 1'b1; fcode = ST_CAPACITY;
                end else begin
                    o_dec.nxt.phase = PH_LIT;
                    if (last) begin
                        fail = 1'b1; fcode = ST_TRUNCATED;
                    end
                end
            end
            PH_LIT: begin
                if (last && i_st.run > 25'd1) begin
                    fail = 1'b1; fcode = ST_TRUNCATED;
                end else begin
                    o_dec.lit_wr             = 1'b1;
                    o_dec.nxt.produced       = i_st.produced + 25'd1;
                    o_dec.emit               = 1'b1;
                    o_dec.res.out_data       = {56'd0, b};
                    o_dec.res.out_count      = 4'd1;
                    o_dec.res.out_status     = ST_OK;
                    if (i_st.run != 25'd0) begin
                        o_dec.nxt.run = i_st.run - 25'd1;
                    end
                    if (i_st.run <= 25'd1) begin
                        o_dec.nxt.phase = PH_OFF0;
                    end
                end
            end
            PH_OFF0: begin
                if (last) begin
                    fail = 1'b1; fcode = ST_TRUNCATED;
                end else begin
                    o_dec.nxt.offset = {8'd0, b};
                    o_dec.nxt.phase  = PH_OFF1;
                end
            end
            PH_OFF1: begin
                if (off == 16'd0) begin
                    fail = 1'b1; fcode = ST_ZERO_OFF;
                end else if ({9'd0, off} > i_st.produced) begin
                    fail = 1'b1; fcode = ST_FAR_OFF;
                end else begin
                    o_dec.nxt.offset = off;
                    if (i_st.nibble == NIB_EXT) begin
                        if (last) begin
                            fail = 1'b1; fcode = ST_TRUNCATED;
                        end else begin
                            match = 1'b1;
                            mlen  = 9'd15 + {5'd0, i_min};
                            o_dec.nxt.phase = PH_MEXT;
                        end
                    end else begin
                        match = 1'b1;
                        mlen  = {5'd0, i_st.nibble} + {5'd0, i_min};
                        o_dec.nxt.phase = PH_TOKEN;
                    end
                end
            end
            PH_MEXT: begin
                if (b == BYTE_EXT && last) begin
                    fail = 1'b1; fcode = ST_TRUNCATED;
                end else begin
                    match = 1'b1;
                    mlen  = {1'b0, b};
                    if (b != BYTE_EXT) begin
                        o_dec.nxt.phase = PH_TOKEN;
                    end
                end
            end
            default: begin
                o_dec.nxt.phase = PH_TOKEN;
            end
        endcase

        if (match) begin
            if ({1'b0, i_st.produced} + {17'd0, mlen} > {2'b0, i_cap}) begin
                fail = 1'b1; fcode = ST_CAPACITY;
            end else begin
                o_dec.nxt.produced = i_st.produced + {16'd0, mlen};
                o_dec.copy         = (mlen != 9'd0);
                o_dec.copy_len     = mlen;
            end
        end

        if (fail) begin
            o_dec.nxt.err  = 1'b1;
            o_dec.nxt.code = fcode;
            o_dec.emit     = 1'b1;
            o_dec.res      = '0;
            o_dec.res.out_status = fcode;
        end

        // Errored block: drop bytes until the final one
        if (i_st.err) begin
            o_dec = '0;
            o_dec.nxt = i_st;
            o_dec.emit = last;
            o_dec.res.out_status = i_st.code;
        end

        if (last) begin
            if (o_dec.emit) begin
                o_dec.res.out_last = 1'b1;
            end else if (!o_dec.copy) begin
                o_dec.emit = 1'b1;
                o_dec.res  = '0;
                o_dec.res.out_last = 1'b1;
            end
            o_dec.nxt.phase    = PH_TOKEN;
            o_dec.nxt.nibble   = '0;
            o_dec.nxt.run      = '0;
            o_dec.nxt.produced = '0;
            o_dec.nxt.err      = 1'b0;
            o_dec.nxt.code     = ST_OK;
        end
    end
endmodule

// ===== rtl/lz4_block_decompressor.sv =====
// Literal bytes: accepted and emitted one per cycle while output is free,
// each registered in the cycle after acceptance. Match bytes: read from
// the history ring, written back, and emitted in packs of up to eight bytes.
// Input is held off while a match copy runs or the output register is full.
// Synchronous active-low reset clears parser, error and pointer state;
// history contents stay undefined until written.
module lz4_block_decompressor import lz4bd_pkg::*; #(
    parameter int WINDOW_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    localparam int AW = $clog2(WINDOW_BYTES);

    t_seq        r_seq, n_seq;
    t_pstate     r_st, n_st;
    logic [AW-1:0] r_wp, n_wp;
    logic [8:0]  r_rem, n_rem;
    logic [3:0]  r_cnt, n_cnt;
    logic [63:0] r_pack, n_pack;
    logic        r_plast, n_plast;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;
    logic [23:0] r_cap;
    logic [3:0]  r_min;

    t_dec        dec;
    logic        out_free;
    logic        in_acc;
    logic        ring_we;
    logic [7:0]  ring_wdata;
    logic        ring_re;
    logic [AW-1:0] ring_raddr;
    logic [7:0]  ring_rdata;

    lz4bd_parse u_parse (
        .i_item (i_in_item),
        .i_st   (r_st),
        .i_cap  (r_cap),
        .i_min  (r_min),
        .o_dec  (dec)
    );

    lz4bd_ring #(.DEPTH(WINDOW_BYTES)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wp),
        .i_wdata (ring_wdata),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_seq == SQ_IDLE) && out_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    assign ring_we    = (in_acc && dec.lit_wr) || (r_seq == SQ_WR);
    assign ring_wdata = (r_seq == SQ_WR) ? ring_rdata : i_in_item.in_byte;
    assign ring_re    = (r_seq == SQ_RD);
    assign ring_raddr = r_wp - r_st.offset[AW-1:0];

    always_comb begin
        n_seq       = r_seq;
        n_st        = r_st;
        n_wp        = r_wp;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_pack      = r_pack;
        n_plast     = r_plast;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_seq)
            SQ_IDLE: begin
                if (in_acc) begin
                    n_st = dec.nxt;
                    if (dec.lit_wr) begin
                        n_wp = r_wp + AW'(1);
                    end
                    if (dec.emit) begin
                        n_out       = dec.res;
                        n_out_valid = 1'b1;
                    end
                    if (dec.copy) begin
                        n_rem   = dec.copy_len;
                        n_cnt   = '0;
                        n_pack  = '0;
                        n_plast = i_in_item.in_last;
                        n_seq   = SQ_RD;
                    end
                end
            end
            SQ_RD: begin
                n_seq = SQ_WR;
            end
            SQ_WR: begin
                n_pack[r_cnt[2:0]*8 +: 8] = ring_rdata;
                n_wp  = r_wp + AW'(1);
                n_rem = r_rem - 9'd1;
                n_cnt = r_cnt + 4'd1;
                // Flush on a full pack or the end of this match part
                n_seq = (r_cnt == 4'd7 || r_rem == 9'd1) ? SQ_EMIT : SQ_RD;
            end
            SQ_EMIT: begin
                if (out_free) begin
                    n_out.out_data   = r_pack;
                    n_out.out_count  = r_cnt;
                    n_out.out_last   = r_plast && (r_rem == 9'd0);
                    n_out.out_status = ST_OK;
                    n_out_valid      = 1'b1;
                    n_cnt  = '0;
                    n_pack = '0;
                    n_seq  = (r_rem == 9'd0) ? SQ_IDLE : SQ_RD;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_st        <= '{phase: PH_TOKEN, default: '0};
            r_wp        <= '0;
            r_rem       <= '0;
            r_cnt       <= '0;
            r_plast     <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= 24'hFF_FFFF;
            r_min       <= 4'd4;
        end else begin
            r_seq       <= n_seq;
            r_st        <= n_st;
            r_wp        <= n_wp;
            r_rem       <= n_rem;
            r_cnt       <= n_cnt;
            r_plast     <= n_plast;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_OUT_CAPACITY: r_cap <= i_cfg_data;
                    CFG_MIN_MATCH:    r_min <= i_cfg_data[3:0];
                    default:          r_cap <= r_cap;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pack <= n_pack;
        r_out  <= n_out;
    end

`include "lz4_block_decompressor_assert.svh"

    `LZ4BD_ASSERT_NOW(a_ready_idle, o_in_ready, r_seq == SQ_IDLE)
    `LZ4BD_ASSERT_NOW(a_emit_nonempty, r_seq == SQ_EMIT, r_cnt != 4'd0 && r_cnt <= 4'd8)
    `LZ4BD_ASSERT_NOW(a_data_ok, r_out_valid && r_out.out_count != 4'd0, r_out.out_status == ST_OK)
    `LZ4BD_ASSERT_NEXT(a_rd_then_wr, r_seq == SQ_RD, r_seq == SQ_WR)

endmodule

// ===== tb/tb_lz4_block_decompressor.sv =====
// Self-checking testbench for the LZ4 block decompressor: directed blocks, then random blocks.
module tb_lz4_block_decompressor;
    import lz4bd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_in_item  req;
        bit        pinned;
        t_out_item want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_OUT_CAPACITY;
    logic [23:0] i_cfg_data = '0;

    lz4_block_decompressor u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder shadow state
    logic [7:0]  ring [0:65535];
    logic [15:0] wr_ptr;
    t_phase      phase;
    logic [3:0]  nibble;
    int unsigned run_len;
    logic [15:0] match_off;
    int unsigned produced;
    bit          err_seen;
    logic [2:0]  err_code;
    int unsigned capacity;
    int unsigned min_len;

    t_out_item   step_out[$];
    t_out_item   pending_out[$];
    t_in_item    blk[$];
    t_row        rows[$];
    int          errors = 0;
    int          sent = 0;
    bit          calm = 1'b0;

    function automatic void add_out(logic [63:0] data, int unsigned cnt, logic [2:0] st);
        t_out_item r;
        r.out_data = data;
        r.out_count = cnt[3:0];
        r.out_last = 1'b0;
        r.out_status = st;
        step_out.push_back(r);
    endfunction

    function automatic void raise_err(logic [2:0] code);
        err_seen = 1'b1;
        err_code = code;
        add_out('0, 0, code);
    endfunction

    function automatic void clear_block();
        phase = PH_TOKEN;
        nibble = '0;
        run_len = 0;
        match_off = '0;
        produced = 0;
        err_seen = 1'b0;
        err_code = ST_OK;
    endfunction

    function automatic void copy_match(int unsigned len);
        logic [63:0] data;
        logic [7:0]  b;
        int unsigned k;
        if (longint'(produced) + len > longint'(capacity)) begin
            raise_err(ST_CAPACITY);
            return;
        end
        produced += len;
        while (len > 0) begin
            k = (len < 8) ? len : 8;
            data = '0;
            for (int i = 0; i < k; i++) begin
                b = ring[wr_ptr - match_off];
                ring[wr_ptr] = b;
                wr_ptr++;
                data |= 64'(b) << (8 * i);
            end
            add_out(data, k, ST_OK);
            len -= k;
        end
    endfunction

    // Decode one compressed byte into step_out
    function automatic void decode_byte(logic [7:0] b, logic last);
        int unsigned lit;
        logic [15:0] off;
        step_out.delete();
        if (err_seen) begin
            if (last) begin
                add_out('0, 0, err_code);
                step_out[0].out_last = 1'b1;
                clear_block();
            end
            return;
        end
        case (phase)
            PH_TOKEN: begin
                lit = b[7:4];
                nibble = b[3:0];
                if (b[7:4] == NIB_EXT) begin
                    run_len = 15;
                    phase = PH_LITEXT;
                    if (last) raise_err(ST_TRUNCATED);
                end else if (lit > 0) begin
                    if (longint'(produced) + lit > longint'(capacity)) begin
                        raise_err(ST_CAPACITY);
                    end else begin
                        run_len = lit;
                        phase = PH_LIT;
                        if (last) raise_err(ST_TRUNCATED);
                    end
                end else begin
                    phase = PH_OFF0;
                end
            end
            PH_LITEXT: begin
                run_len = (run_len + b > RUN_MAX) ? RUN_MAX : run_len + b;
                if (b == BYTE_EXT) begin
                    if (last) raise_err(ST_TRUNCATED);
                end else if (longint'(produced) + run_len > longint'(capacity)) begin
                    raise_err(ST_CAPACITY);
                end else begin
                    phase = PH_LIT;
                    if (last) raise_err(ST_TRUNCATED);
                end
            end
            PH_LIT: begin
                if (last && run_len > 1) begin
                    raise_err(ST_TRUNCATED);
                end else begin
                    ring[wr_ptr] = b;
                    wr_ptr++;
                    produced++;
                    add_out(64'(b), 1, ST_OK);
                    if (run_len > 0) run_len--;
                    if (run_len == 0) phase = PH_OFF0;
                end
            end
            PH_OFF0: begin
                if (last) begin
                    raise_err(ST_TRUNCATED);
                end else begin
                    match_off = {8'h00, b};
                    phase = PH_OFF1;
                end
            end
            PH_OFF1: begin
                off = {b, match_off[7:0]};
                if (off == 0) begin
                    raise_err(ST_ZERO_OFF);
                end else if (off > produced) begin
                    raise_err(ST_FAR_OFF);
                end else begin
                    match_off = off;
                    if (nibble == NIB_EXT) begin
                        if (last) begin
                            raise_err(ST_TRUNCATED);
                        end else begin
                            copy_match(15 + min_len);
                            phase = PH_MEXT;
                        end
                    end else begin
                        copy_match(nibble + min_len);
                        phase = PH_TOKEN;
                    end
                end
            end
            PH_MEXT: begin
                if (b == BYTE_EXT && last) begin
                    raise_err(ST_TRUNCATED);
                end else begin
                    copy_match(b);
                    if (b != BYTE_EXT) phase = PH_TOKEN;
                end
            end
            default: phase = PH_TOKEN;
        endcase
        if (last) begin
            if (step_out.size() == 0) add_out('0, 0, ST_OK);
            step_out[step_out.size() - 1].out_last = 1'b1;
            clear_block();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic void add_row(logic [7:0] b, logic last);
        t_row r;
        r.req.in_byte = b;
        r.req.in_last = last;
        r.pinned = 1'b0;
        r.want = '0;
        rows.push_back(r);
    endfunction

    function automatic void add_pinned(logic [7:0] b, logic last, logic [63:0] data,
                                       logic [3:0] cnt, logic lst, logic [2:0] st);
        t_row r;
        r.req.in_byte = b;
        r.req.in_last = last;
        r.pinned = 1'b1;
        r.want.out_data = data;
        r.want.out_count = cnt;
        r.want.out_last = lst;
        r.want.out_status = st;
        rows.push_back(r);
    endfunction

    // Send one request; a pinned row replaces the decoded results with the typed one
    task automatic send_req(t_in_item req, bit pinned, t_out_item want);
        int gap;
        i_in_valid <= 1'b1;
        i_in_item <= req;
        do @(posedge i_clk); while (!o_in_ready);
        decode_byte(req.in_byte, req.in_last);
        if (pinned) begin
            pending_out.push_back(want);
        end else begin
            foreach (step_out[i]) pending_out.push_back(step_out[i]);
        end
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic idx, int unsigned value);
        i_in_valid <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[23:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_OUT_CAPACITY) capacity = value & 24'hFF_FFFF;
        else min_len = value & 4'hF;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid so the last request is not taken again, then wait for results
    task automatic drain();
        int guard;
        i_in_valid <= 1'b0;
        guard = 0;
        while (pending_out.size() > 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    // Build one block: mostly well-formed sequences, some cut short, some noise
    task automatic build_block();
        int kind, nseq, lit, m, off, rem, est, r, cut;
        t_in_item it;
        blk.delete();
        kind = $urandom_range(0, 9);
        est = 0;
        it.in_last = 1'b0;
        if (kind == 0) begin
            repeat ($urandom_range(1, 10)) begin
                it.in_byte = 8'($urandom());
                blk.push_back(it);
            end
        end else begin
            nseq = $urandom_range(1, 4);
            for (int s = 0; s < nseq; s++) begin
                r = $urandom_range(0, 19);
                if (r == 0) lit = $urandom_range(15, 300);
                else if (r < 4) lit = 0;
                else lit = $urandom_range(1, 14);
                if (est == 0 && lit == 0) lit = 1;
                m = $urandom_range(0, 15);
                it.in_byte = {4'((lit >= 15) ? 15 : lit), 4'(m)};
                blk.push_back(it);
                if (lit >= 15) begin
                    rem = lit - 15;
                    while (rem >= 255) begin
                        it.in_byte = BYTE_EXT;
                        blk.push_back(it);
                        rem -= 255;
                    end
                    it.in_byte = 8'(rem);
                    blk.push_back(it);
                end
                repeat (lit) begin
                    it.in_byte = 8'($urandom());
                    blk.push_back(it);
                end
                est += lit;
                if (s == nseq - 1 && $urandom_range(0, 2) == 0) break;
                off = $urandom_range(1, (est > 65535) ? 65535 : est);
                r = $urandom_range(0, 19);
                if (r == 0) off = 0;
                else if (r == 1 && est < 65535) off = est + 1;
                it.in_byte = 8'(off);
                blk.push_back(it);
                it.in_byte = 8'(off >> 8);
                blk.push_back(it);
                if (m == 15) begin
                    if ($urandom_range(0, 3) == 0) begin
                        it.in_byte = BYTE_EXT;
                        blk.push_back(it);
                    end
                    it.in_byte = 8'($urandom_range(0, 60));
                    blk.push_back(it);
                end
                est += m + 1;
            end
            if (kind == 1) begin
                cut = $urandom_range(1, blk.size());
                while (blk.size() > cut) void'(blk.pop_back());
            end
        end
        blk[blk.size() - 1].in_last = 1'b1;
    endtask

    // Output side: random backpressure
    int hold = 0;
    always @(posedge i_clk) begin
        if (hold > 0) begin
            i_out_ready <= 1'b0;
            hold <= hold - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) hold <= pick_gap() + 1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out_item;
            if (pending_out.size() == 0) begin
                $display("%0t: unexpected result data=%h count=%0d last=%0b status=%0d",
                         $realtime, got.out_data, got.out_count, got.out_last, got.out_status);
                errors++;
            end else begin
                want = pending_out.pop_front();
                if (got.out_data !== want.out_data) begin
                    $display("%0t: out_data expected %h actual %h",
                             $realtime, want.out_data, got.out_data);
                    errors++;
                end
                if (got.out_count !== want.out_count) begin
                    $display("%0t: out_count expected %0d actual %0d",
                             $realtime, want.out_count, got.out_count);
                    errors++;
                end
                if (got.out_last !== want.out_last) begin
                    $display("%0t: out_last expected %0b actual %0b",
                             $realtime, want.out_last, got.out_last);
                    errors++;
                end
                if (got.out_status !== want.out_status) begin
                    $display("%0t: out_status expected %0d actual %0d",
                             $realtime, want.out_status, got.out_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("tb_lz4_block_decompressor failed");
        $finish;
    end

    initial begin
        int unsigned caps [6];
        int unsigned mins [6];
        int start;
        t_out_item none;
        none = '0;
        wr_ptr = '0;
        capacity = 24'hFF_FFFF;
        min_len = 4;
        clear_block();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Literal-only block, empty block, then a block with overlapping copies
        add_row(8'h10, 1'b0);
        add_pinned(8'h5A, 1'b1, 64'h5A, 4'd1, 1'b1, ST_OK);
        add_pinned(8'h00, 1'b1, '0, 4'd0, 1'b1, ST_OK);
        add_row(8'h30, 1'b0); add_row(8'h00, 1'b0); add_row(8'hFF, 1'b0);
        add_row(8'hA5, 1'b0); add_row(8'h01, 1'b0); add_row(8'h00, 1'b0);
        add_row(8'h0F, 1'b0); add_row(8'h02, 1'b0); add_row(8'h00, 1'b0);
        add_row(8'hFF, 1'b0); add_row(8'h05, 1'b1);
        // Zero offset, then the error is held until the block end
        add_row(8'h10, 1'b0); add_row(8'h77, 1'b0); add_row(8'h00, 1'b0);
        add_pinned(8'h00, 1'b0, '0, 4'd0, 1'b0, ST_ZERO_OFF);
        add_pinned(8'h12, 1'b1, '0, 4'd0, 1'b1, ST_ZERO_OFF);
        // Offset beyond the bytes produced
        add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
        add_pinned(8'h05, 1'b0, '0, 4'd0, 1'b0, ST_FAR_OFF);
        add_pinned(8'h00, 1'b1, '0, 4'd0, 1'b1, ST_FAR_OFF);
        // Literals cut short by the block end
        add_row(8'h20, 1'b0);
        add_pinned(8'h33, 1'b1, '0, 4'd0, 1'b1, ST_TRUNCATED);
        foreach (rows[i]) send_req(rows[i].req, rows[i].pinned, rows[i].want);
        drain();

        // Small capacity forces the capacity error on a literal run
        write_reg(CFG_OUT_CAPACITY, 0);
        send_req('{in_byte: 8'h10, in_last: 1'b1}, 1'b1,
                 '{out_data: '0, out_count: 4'd0, out_last: 1'b1, out_status: ST_CAPACITY});
        drain();

        caps = '{24'hFF_FFFF, 0, 0, 24'hFF_FFFF, 0, 24'hFF_FFFF};
        mins = '{4, 1, 15, 0, 0, 15};
        caps[2] = $urandom_range(20, 400);
        caps[4] = $urandom_range(0, 24'hFF_FFFF);
        mins[4] = $urandom_range(0, 15);
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_OUT_CAPACITY, caps[p]);
            write_reg(CFG_MIN_MATCH, mins[p]);
            calm = (p == 3);
            start = sent;
            while (sent - start < 80) begin
                build_block();
                foreach (blk[i]) send_req(blk[i], 1'b0, none);
            end
            i_in_valid <= 1'b0;
            drain();
        end

        if (errors == 0 && pending_out.size() == 0) begin
            $display("tb_lz4_block_decompressor passed");
        end else begin
            $display("tb_lz4_block_decompressor failed");
        end
        $finish;
    end
endmodule
